>>> hw/rtl/pmbd_pkg.sv
// Shared constants, Bayer matrix and CSR codes for the palette match and dither block.
package pmbd_pkg;

   // Palette geometry
   localparam int PALETTE_SIZE = 16;
   localparam int IDX_W        = $clog2(PALETTE_SIZE);
   localparam int CNT_W        = 5;
   localparam int ARGB_W       = 32;
   localparam int RGB_W        = 24;
   localparam int CHAN_W       = 8;
   localparam int DIST_W       = 10;
   localparam int PHASE_W      = 3;
   localparam int SCALE_W      = 7;
   localparam int TOTAL_W      = 32;

   // Only fully opaque pixels are matched; a dithered rematch needs an opaque entry
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // Dither scale is (128 - m) / 128
   localparam logic [SCALE_W:0] DITHER_ONE = 8'd128;

   // CSR register indexes
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PALETTE_COUNT = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DITHER_ENABLE = 1'b1;

   // 8x8 Bayer matrix, indexed by {x_phase, y_phase}
   localparam logic [SCALE_W-1:0] BAYER_ROM [64] = '{
      7'd1,  7'd49, 7'd13, 7'd61, 7'd4,  7'd52, 7'd16, 7'd64,
      7'd33, 7'd17, 7'd45, 7'd29, 7'd36, 7'd20, 7'd48, 7'd32,
      7'd9,  7'd57, 7'd5,  7'd53, 7'd12, 7'd60, 7'd8,  7'd56,
      7'd41, 7'd25, 7'd37, 7'd21, 7'd44, 7'd28, 7'd40, 7'd24,
      7'd3,  7'd51, 7'd15, 7'd63, 7'd2,  7'd50, 7'd14, 7'd62,
      7'd35, 7'd19, 7'd47, 7'd31, 7'd34, 7'd18, 7'd46, 7'd30,
      7'd11, 7'd59, 7'd7,  7'd55, 7'd10, 7'd58, 7'd6,  7'd54,
      7'd43, 7'd27, 7'd39, 7'd23, 7'd42, 7'd26, 7'd38, 7'd22
   };

   // Scale one channel: floor(c * (128 - m) / 128)
   function automatic logic [CHAN_W-1:0] dither_chan(input logic [CHAN_W-1:0] c,
                                                     input logic [SCALE_W-1:0] k);
      logic [CHAN_W+SCALE_W-1:0] prod;
      prod = c * k;
      return prod[CHAN_W+SCALE_W-1:SCALE_W];
   endfunction

endpackage

>>> hw/rtl/pmbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pmbd_dist.sv
// Manhattan RGB distance between the pixel under test and one palette entry.
module pmbd_dist (
   input  logic [pmbd_pkg::RGB_W-1:0]  pix_rgb,
   input  logic [pmbd_pkg::RGB_W-1:0]  ent_rgb,
   output logic [pmbd_pkg::DIST_W-1:0] dist_sum
);
   import pmbd_pkg::*;

   logic [CHAN_W-1:0] diff_r, diff_g, diff_b;

   // absolute difference per channel
   always_comb begin
      diff_r = (pix_rgb[23:16] > ent_rgb[23:16]) ? pix_rgb[23:16] - ent_rgb[23:16]
                                                 : ent_rgb[23:16] - pix_rgb[23:16];
      diff_g = (pix_rgb[15:8] > ent_rgb[15:8]) ? pix_rgb[15:8] - ent_rgb[15:8]
                                               : ent_rgb[15:8] - pix_rgb[15:8];
      diff_b = (pix_rgb[7:0] > ent_rgb[7:0]) ? pix_rgb[7:0] - ent_rgb[7:0]
                                             : ent_rgb[7:0] - pix_rgb[7:0];
   end

   assign dist_sum = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);

endmodule

>>> hw/rtl/palette_match_bayer_dither_unit.sv
// Nearest palette colour search with optional 8x8 ordered dither and rematch.
//
// Request channel (req_*, valid/ready): op 0 loads entry_argb into palette slot
// entry_index and gives no response; op 1 matches pixel_argb against the first
// palette_count entries (saturated to 16) by Manhattan RGB distance, lowest
// index winning ties. A non-opaque pixel or an empty palette gives no colour.
// Response channel (rsp_*, valid/ready): colour index, hit flag and the running
// count of successful first matches.
// CSR port: write-only, index 0 palette_count, index 1 dither_enable; write only
// while idle.
// Flow: a load writes the palette as it is taken and leaves the sequencer idle.
// A pixel walks the palette RAM one entry per cycle through a single distance
// unit in ST_SCAN, then passes ST_DRAIN and ST_DONE; with dithering ST_DRAIN
// goes on to ST_DMUL and a second scan with the dithered colour. A rejected
// pixel goes from ST_IDLE straight to ST_DONE. One request is in flight at a
// time; req_ready is high only when the sequencer is idle.
// A finished response sits in an output register; if the receiver stalls and
// that register is still full, the sequencer holds its result until it frees.
// Reset clears the counter, CSRs and control; palette contents stay undefined.
module palette_match_bayer_dither_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic [pmbd_pkg::IDX_W-1:0]       req_entry_index,
   input  logic [pmbd_pkg::ARGB_W-1:0]      req_entry_argb,
   input  logic [pmbd_pkg::ARGB_W-1:0]      req_pixel_argb,
   input  logic [pmbd_pkg::PHASE_W-1:0]     req_x_phase,
   input  logic [pmbd_pkg::PHASE_W-1:0]     req_y_phase,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pmbd_pkg::IDX_W-1:0]       rsp_color_index,
   output logic                             rsp_has_color,
   output logic [pmbd_pkg::TOTAL_W-1:0]     rsp_match_total,
   // CSR write port
   input  logic                             csr_we,
   input  logic [pmbd_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  logic [pmbd_pkg::CNT_W-1:0]       csr_wdata
);
   import pmbd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DMUL,
      ST_DONE
   } state_type;

   state_type             state_ff;
   logic [RGB_W-1:0]      pix_ff;
   logic [2*PHASE_W-1:0]  phase_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic                  cmp_vld_ff;
   logic [IDX_W-1:0]      cmp_idx_ff;
   logic [DIST_W-1:0]     best_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic                  found_ff;
   logic                  pass2_ff;
   logic [IDX_W-1:0]      res_idx_ff;
   logic                  res_hit_ff;
   logic [TOTAL_W-1:0]    count_ff;
   logic [CNT_W-1:0]      pal_count_ff;
   logic                  dith_en_ff;
   logic                  rsp_valid_ff;
   logic [IDX_W-1:0]      rsp_idx_ff;
   logic                  rsp_hit_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;

   logic                  req_fire;
   logic [CNT_W-1:0]      n_entries;
   logic [CNT_W-1:0]      last_entry;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [ARGB_W-1:0]     ram_rd_data;
   logic [DIST_W-1:0]     dist_sum;
   logic                  hit_in;
   logic [IDX_W-1:0]      best_idx_in;
   logic [SCALE_W-1:0]    scale;
   logic [RGB_W-1:0]      dith_rgb;
   logic                  out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // entries searched, saturated to the palette size
   assign n_entries  = (pal_count_ff > CNT_W'(PALETTE_SIZE)) ? CNT_W'(PALETTE_SIZE)
                                                              : pal_count_ff;
   assign last_entry = n_entries - CNT_W'(1);

   // palette write on load requests; every 4-bit slot lies inside the palette
   assign ram_wr_en = req_fire && !req_op;

   // read port: scan address while searching, winning entry for the dither fetch
   assign ram_rd_en   = (state_ff == ST_SCAN) ||
                        ((state_ff == ST_DRAIN) && !pass2_ff && dith_en_ff);
   assign ram_rd_addr = (state_ff == ST_SCAN) ? idx_ff : best_idx_in;

   pmbd_ram #(
      .WIDTH (ARGB_W),
      .DEPTH (PALETTE_SIZE)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_entry_index),
      .wr_data (req_entry_argb),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pmbd_dist u_dist (
      .pix_rgb  (pix_ff),
      .ent_rgb  (ram_rd_data[RGB_W-1:0]),
      .dist_sum (dist_sum)
   );

   // running minimum, strict less-than keeps the lowest index on ties
   assign hit_in      = cmp_vld_ff && (!found_ff || (dist_sum < best_ff));
   assign best_idx_in = hit_in ? cmp_idx_ff : best_idx_ff;

   // dithered colour of the fetched entry
   assign scale    = SCALE_W'(DITHER_ONE - {1'b0, BAYER_ROM[phase_ff]});
   assign dith_rgb = {dither_chan(ram_rd_data[23:16], scale),
                      dither_chan(ram_rd_data[15:8], scale),
                      dither_chan(ram_rd_data[7:0], scale)};

   // sequencer, search state, counter, CSRs and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         pass2_ff     <= 1'b0;
         count_ff     <= '0;
         pal_count_ff <= '0;
         dith_en_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // CSR writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_PALETTE_COUNT: pal_count_ff <= csr_wdata;
               CSR_DITHER_ENABLE: dith_en_ff   <= csr_wdata[0];
               default: ;
            endcase
         end

         // compare stage sees each RAM read in the cycle after it is issued
         cmp_vld_ff <= (state_ff == ST_SCAN);
         cmp_idx_ff <= idx_ff;
         if (hit_in) begin
            found_ff    <= 1'b1;
            best_ff     <= dist_sum;
            best_idx_ff <= cmp_idx_ff;
         end

         // response taken; a waiting result reloads the register in ST_DONE
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_op) begin
                  pix_ff   <= req_pixel_argb[RGB_W-1:0];
                  phase_ff <= {req_x_phase, req_y_phase};
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  pass2_ff <= 1'b0;
                  if ((req_pixel_argb[31:24] != ALPHA_OPAQUE) || (n_entries == '0)) begin
                     res_idx_ff <= '0;
                     res_hit_ff <= 1'b0;
                     state_ff   <= ST_DONE;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               idx_ff <= idx_ff + IDX_W'(1);
               if (idx_ff == last_entry[IDX_W-1:0]) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // last compare lands this cycle; decide on the combined result
               if (!pass2_ff) begin
                  count_ff <= count_ff + TOTAL_W'(1);
               end
               if (!pass2_ff && dith_en_ff) begin
                  state_ff <= ST_DMUL;
               end else begin
                  res_idx_ff <= best_idx_in;
                  res_hit_ff <= 1'b1;
                  state_ff   <= ST_DONE;
               end
            end
            ST_DMUL: begin
               // rematch with the dithered colour, entry alpha must be opaque
               if (ram_rd_data[31:24] != ALPHA_OPAQUE) begin
                  res_idx_ff <= '0;
                  res_hit_ff <= 1'b0;
                  state_ff   <= ST_DONE;
               end else begin
                  pix_ff   <= dith_rgb;
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  pass2_ff <= 1'b1;
                  state_ff <= ST_SCAN;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_idx_ff   <= res_idx_ff;
                  rsp_hit_ff   <= res_hit_ff;
                  rsp_total_ff <= count_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_idx_ff;
   assign rsp_has_color   = rsp_hit_ff;
   assign rsp_match_total = rsp_total_ff;

endmodule

>>> bench/palette_match_bayer_dither_unit_tb.sv
// Self-checking testbench for the palette match and ordered dither unit.
module palette_match_bayer_dither_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pmbd_pkg::*;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_PIXEL = 1'b1
   } req_op_type;

   typedef struct {
      req_op_type           op;
      logic [IDX_W-1:0]     slot;
      logic [ARGB_W-1:0]    entry_argb;
      logic [ARGB_W-1:0]    pixel_argb;
      logic [PHASE_W-1:0]   x_phase;
      logic [PHASE_W-1:0]   y_phase;
   } palette_req_type;

   typedef struct {
      logic [IDX_W-1:0]     color_index;
      logic                 has_color;
      logic [TOTAL_W-1:0]   match_total;
   } match_result_type;

   // 8x8 threshold matrix, indexed by {x_phase, y_phase}
   localparam bit [6:0] THRESHOLD_MAP [64] = '{
      7'd1,  7'd49, 7'd13, 7'd61, 7'd4,  7'd52, 7'd16, 7'd64,
      7'd33, 7'd17, 7'd45, 7'd29, 7'd36, 7'd20, 7'd48, 7'd32,
      7'd9,  7'd57, 7'd5,  7'd53, 7'd12, 7'd60, 7'd8,  7'd56,
      7'd41, 7'd25, 7'd37, 7'd21, 7'd44, 7'd28, 7'd40, 7'd24,
      7'd3,  7'd51, 7'd15, 7'd63, 7'd2,  7'd50, 7'd14, 7'd62,
      7'd35, 7'd19, 7'd47, 7'd31, 7'd34, 7'd18, 7'd46, 7'd30,
      7'd11, 7'd59, 7'd7,  7'd55, 7'd10, 7'd58, 7'd6,  7'd54,
      7'd43, 7'd27, 7'd39, 7'd23, 7'd42, 7'd26, 7'd38, 7'd22
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_op = 1'b0;
   logic [IDX_W-1:0]      req_entry_index = '0;
   logic [ARGB_W-1:0]     req_entry_argb = '0;
   logic [ARGB_W-1:0]     req_pixel_argb = '0;
   logic [PHASE_W-1:0]    req_x_phase = '0;
   logic [PHASE_W-1:0]    req_y_phase = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [IDX_W-1:0]      rsp_color_index;
   logic                  rsp_has_color;
   logic [TOTAL_W-1:0]    rsp_match_total;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CNT_W-1:0]      csr_wdata = '0;

   // Shadow of the block's state and registers
   logic [ARGB_W-1:0]     palette_shadow [PALETTE_SIZE];
   logic [TOTAL_W-1:0]    match_counter = '0;
   logic [CNT_W-1:0]      cfg_palette_count = '0;
   logic                  cfg_dither = 1'b0;

   // Colours already queued, used only to bias the stimulus towards near matches and ties
   logic [ARGB_W-1:0]     queued_palette [PALETTE_SIZE] = '{default: '0};

   palette_req_type       pending_reqs [$];
   palette_req_type       active_req;
   match_result_type      expected_matches [$];

   int                    idle_odds = 0;
   int                    send_gap = 0;
   int                    stall_left = 0;
   int                    mismatch_count = 0;
   int                    loads_done = 0;
   int                    pixels_done = 0;
   int                    responses_seen = 0;
   int                    colour_hits = 0;
   int                    settings_used = 0;

   palette_match_bayer_dither_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_entry_index (req_entry_index),
      .req_entry_argb  (req_entry_argb),
      .req_pixel_argb  (req_pixel_argb),
      .req_x_phase     (req_x_phase),
      .req_y_phase     (req_y_phase),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_color_index (rsp_color_index),
      .rsp_has_color   (rsp_has_color),
      .rsp_match_total (rsp_match_total),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned chan_gap(input logic [CHAN_W-1:0] a,
                                            input logic [CHAN_W-1:0] b);
      return (a > b) ? int'(a - b) : int'(b - a);
   endfunction

   // Nearest opaque match over the active entries; strict less-than keeps the lowest index
   function automatic logic find_nearest(input logic [ARGB_W-1:0] argb,
                                         output logic [IDX_W-1:0] idx);
      int unsigned n;
      int unsigned d;
      int unsigned best;
      logic        found;
      logic [ARGB_W-1:0] e;
      idx   = '0;
      found = 1'b0;
      best  = 0;
      n     = (cfg_palette_count > PALETTE_SIZE) ? PALETTE_SIZE : cfg_palette_count;
      if (argb[31:24] != 8'hFF)
         return 1'b0;
      for (int i = 0; i < n; i++) begin
         e = palette_shadow[i];
         d = chan_gap(argb[23:16], e[23:16]) + chan_gap(argb[15:8], e[15:8])
             + chan_gap(argb[7:0], e[7:0]);
         if (!found || d < best) begin
            found = 1'b1;
            best  = d;
            idx   = IDX_W'(i);
         end
      end
      return found;
   endfunction

   // floor(c * (128 - m) / 128)
   function automatic logic [CHAN_W-1:0] dim_channel(input logic [CHAN_W-1:0] c,
                                                     input bit [6:0] m);
      logic [15:0] prod;
      prod = {8'd0, c} * (16'd128 - {9'd0, m});
      return prod[14:7];
   endfunction

   // Update the shadow state for one accepted request and log the response it owes
   task automatic apply_request(input palette_req_type rq);
      match_result_type  res;
      logic [IDX_W-1:0]  idx;
      logic              hit;
      logic [ARGB_W-1:0] e;
      bit [6:0]          m;
      if (rq.op == OP_LOAD) begin
         palette_shadow[rq.slot] = rq.entry_argb;
         loads_done++;
         return;
      end
      pixels_done++;
      hit = find_nearest(rq.pixel_argb, idx);
      if (hit) begin
         match_counter++;
         if (cfg_dither) begin
            e   = palette_shadow[idx];
            m   = THRESHOLD_MAP[{rq.x_phase, rq.y_phase}];
            hit = find_nearest({e[31:24], dim_channel(e[23:16], m),
                                dim_channel(e[15:8], m), dim_channel(e[7:0], m)}, idx);
         end
      end
      res.color_index = hit ? idx : '0;
      res.has_color   = hit;
      res.match_total = match_counter;
      expected_matches.insert(expected_matches.size(), res);
   endtask

   task automatic queue_load(input int slot, input logic [ARGB_W-1:0] argb);
      palette_req_type rq;
      rq.op         = OP_LOAD;
      rq.slot       = IDX_W'(slot);
      rq.entry_argb = argb;
      rq.pixel_argb = $urandom;
      rq.x_phase    = PHASE_W'($urandom);
      rq.y_phase    = PHASE_W'($urandom);
      queued_palette[slot] = argb;
      pending_reqs.insert(pending_reqs.size(), rq);
   endtask

   task automatic queue_pixel(input logic [ARGB_W-1:0] argb, input int xp, input int yp);
      palette_req_type rq;
      rq.op         = OP_PIXEL;
      rq.slot       = IDX_W'($urandom);
      rq.entry_argb = $urandom;
      rq.pixel_argb = argb;
      rq.x_phase    = PHASE_W'(xp);
      rq.y_phase    = PHASE_W'(yp);
      pending_reqs.insert(pending_reqs.size(), rq);
   endtask

   // Mostly opaque pixels, half of them near palette colours, some loads, some noise
   task automatic queue_random_traffic(input int count);
      logic [7:0]  alpha;
      logic [23:0] rgb;
      logic [23:0] base;
      int          c;
      for (int n = 0; n < count; n++) begin
         alpha = ($urandom_range(0, 99) < 85) ? 8'hFF : 8'($urandom);
         if ($urandom_range(0, 99) < 15) begin
            // palette rewrite, sometimes duplicating another entry to force ties
            if ($urandom_range(0, 99) < 30)
               rgb = queued_palette[$urandom_range(0, PALETTE_SIZE - 1)][23:0];
            else
               rgb = 24'($urandom);
            queue_load($urandom_range(0, PALETTE_SIZE - 1), {alpha, rgb});
         end else begin
            if ($urandom_range(0, 1) == 0) begin
               rgb = 24'($urandom);
            end else begin
               base = queued_palette[$urandom_range(0, PALETTE_SIZE - 1)][23:0];
               for (int k = 0; k < 3; k++) begin
                  c = int'(base[8*k +: 8]) + int'($urandom_range(0, 8)) - 4;
                  if (c < 0)
                     c = 0;
                  if (c > 255)
                     c = 255;
                  rgb[8*k +: 8] = 8'(c);
               end
            end
            queue_pixel({alpha, rgb}, $urandom_range(0, 7), $urandom_range(0, 7));
         end
      end
   endtask

   // Block idle: nothing queued, nothing presented, nothing outstanding
   task automatic wait_quiet();
      while (pending_reqs.size() != 0 || req_valid || expected_matches.size() != 0)
         @(negedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [CNT_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_PALETTE_COUNT)
         cfg_palette_count = data;
      else
         cfg_dither = data[0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input int count, input int dither, input int odds);
      wait_quiet();
      write_csr(CSR_PALETTE_COUNT, CNT_W'(count));
      write_csr(CSR_DITHER_ENABLE, CNT_W'(dither));
      idle_odds = odds;
      settings_used++;
      @(negedge clock);
   endtask

   // Request driver: presents queued requests, with random gaps when idle_odds is nonzero
   always @(posedge clock) begin : request_driver
      logic presenting;
      logic launch;
      presenting = req_valid;
      launch     = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            apply_request(active_req);
            presenting = 1'b0;
         end
         if (!presenting) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_reqs.size() != 0) begin
               if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
                  send_gap = $urandom_range(0, 11);
               end else begin
                  active_req = pending_reqs.pop_front();
                  launch     = 1'b1;
                  presenting = 1'b1;
               end
            end
         end
      end
      req_valid <= presenting;
      if (launch) begin
         req_op          <= active_req.op;
         req_entry_index <= active_req.slot;
         req_entry_argb  <= active_req.entry_argb;
         req_pixel_argb  <= active_req.pixel_argb;
         req_x_phase     <= active_req.x_phase;
         req_y_phase     <= active_req.y_phase;
      end
   end

   // Response back-pressure in random bursts when idle_odds is nonzero
   always @(posedge clock) begin : response_pacer
      logic ready_next;
      ready_next = 1'b1;
      if (stall_left > 0) begin
         stall_left--;
         ready_next = 1'b0;
      end else if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
         stall_left = $urandom_range(0, 11);
         ready_next = 1'b0;
      end
      rsp_ready <= ready_next;
   end

   // Response checker against the oldest outstanding expectation
   always @(posedge clock) begin : response_checker
      match_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (rsp_has_color === 1'b1)
            colour_hits++;
         if (expected_matches.size() == 0) begin
            $display("%0t: unexpected response: index %0d has_color %0b total %0d",
                     $time, rsp_color_index, rsp_has_color, rsp_match_total);
            mismatch_count++;
         end else begin
            want = expected_matches.pop_front();
            if (rsp_color_index !== want.color_index) begin
               $display("%0t: color_index expected %0d actual %0d",
                        $time, want.color_index, rsp_color_index);
               mismatch_count++;
            end
            if (rsp_has_color !== want.has_color) begin
               $display("%0t: has_color expected %0b actual %0b",
                        $time, want.has_color, rsp_has_color);
               mismatch_count++;
            end
            if (rsp_match_total !== want.match_total) begin
               $display("%0t: match_total expected %0d actual %0d",
                        $time, want.match_total, rsp_match_total);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus sequence
   initial begin : stimulus
      int phase_count [9];
      int phase_dither [9];
      phase_count  = '{16, 16, 31, 17, 1, 0, 2, -1, -1};
      phase_dither = '{0, 1, 1, 0, 1, 0, 1, -1, -1};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty palette, then a few hand-picked entries (slot 3 duplicates slot 0)
      set_config(0, 0, 0);
      queue_pixel(32'hFF123456, 0, 0);
      queue_load(0, 32'hFF000000);
      queue_load(1, 32'hFFFFFFFF);
      queue_load(2, 32'h00808080);
      queue_load(3, 32'hFF000000);
      queue_pixel(32'hFFFFFFFF, 7, 7);

      // plain matching: tie, extremes, translucent entry, translucent pixels
      set_config(4, 0, 15);
      queue_pixel(32'hFF000000, 1, 2);
      queue_pixel(32'hFFFFFFFF, 3, 4);
      queue_pixel(32'hFF808080, 5, 6);
      queue_pixel(32'h7F808080, 0, 0);
      queue_pixel(32'h00FFFFFF, 7, 7);

      // dithered: rematch of a translucent entry fails, threshold extremes
      set_config(4, 1, 15);
      queue_pixel(32'hFF808080, 0, 0);
      queue_pixel(32'hFFFFFFFF, 0, 7);
      queue_pixel(32'hFFFFFFFF, 7, 7);
      queue_pixel(32'hFF000000, 7, 0);
      queue_pixel(32'hFFF0F0F0, 3, 5);

      // fill the rest of the palette before wider searches
      for (int s = 4; s < PALETTE_SIZE; s++)
         queue_load(s, {($urandom_range(0, 99) < 85) ? 8'hFF : 8'($urandom), 24'($urandom)});

      for (int p = 0; p < 9; p++) begin
         if (phase_count[p] < 0)
            set_config($urandom_range(0, 31), $urandom_range(0, 1), (p % 3) * 20);
         else
            set_config(phase_count[p], phase_dither[p], (p % 3) * 20);
         queue_random_traffic(72);
      end

      // closing stretch at full rate
      set_config(16, 1, 0);
      queue_random_traffic(80);

      wait_quiet();
      repeat (50) @(posedge clock);
      $display("Covered %0d palette loads and %0d pixels across %0d register settings.",
               loads_done, pixels_done, settings_used);
      $display("Checked %0d responses, %0d of them with a colour; %0d mismatches.",
               responses_seen, colour_hits, mismatch_count);
      if (mismatch_count == 0 && expected_matches.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #4000000;
      $display("%0t: run did not complete, %0d requests queued, %0d responses outstanding",
               $time, pending_reqs.size(), expected_matches.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
